### rtl/core/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int MAX_TEXT    = 4096;
    localparam int ALPHABET    = 26;
    localparam int NODES       = MAX_TEXT + 2;
    localparam int EDGE_DEPTH  = NODES * ALPHABET;
    localparam int SYM_W       = 5;
    localparam int POS_W       = $clog2(MAX_TEXT);
    localparam int LEN_W       = $clog2(MAX_TEXT + 1);
    localparam int NODE_W      = $clog2(NODES);
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int CNT_W       = 13;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_CLEARED  = 2'd2,
        ST_BAD      = 2'd3
    } status_e;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDCUR,
        S_CURD,
        S_WNODE,
        S_WTEXT,
        S_WCMP,
        S_EDGE,
        S_EDGED,
        S_CHK,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [4:0] symbol;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        logic [12:0] suffix_node;
        logic [12:0] suffix_length;
        logic        created;
        logic [12:0] end_count;
        logic [11:0] first_position;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [NODE_W-1:0] link;
        logic [CNT_W-1:0]  cnt;
        logic [POS_W-1:0]  first;
        logic [NODE_W-1:0] parent;
        logic [SYM_W-1:0]  letter;
    } node_rec_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
    } node_rd_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        node_rec_t         data;
    } node_wr_t;

endpackage

### rtl/core/ptb_text_store.sv
// ----------------------------------------------------------------------------
// ptb_text_store
// Symbol memory of the text, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ptb_text_store (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ptb_pkg::POS_W-1:0] wr_addr,
    input  logic [ptb_pkg::SYM_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ptb_pkg::POS_W-1:0] rd_addr,
    output logic [ptb_pkg::SYM_W-1:0] rd_data
);
    import ptb_pkg::*;

    logic [SYM_W-1:0] mem [MAX_TEXT];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ptb_node_store.sv
// ----------------------------------------------------------------------------
// ptb_node_store
// Per-node record memory: length, suffix link, count, first end position, parent and letter.
// ----------------------------------------------------------------------------
module ptb_node_store (
    input  logic               clk,
    input  ptb_pkg::node_rd_t  rd,
    input  ptb_pkg::node_wr_t  wr,
    output ptb_pkg::node_rec_t rd_data
);
    import ptb_pkg::*;

    node_rec_t mem [NODES];
    node_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ptb_edge_store.sv
// ----------------------------------------------------------------------------
// ptb_edge_store
// Transition memory indexed by node and letter. An entry is trusted only when
// the named child records that same parent and letter.
// ----------------------------------------------------------------------------
module ptb_edge_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [ptb_pkg::EDGE_AW-1:0] addr,
    input  logic [ptb_pkg::NODE_W-1:0]  wr_data,
    output logic [ptb_pkg::NODE_W-1:0]  rd_data
);
    import ptb_pkg::*;

    logic [NODE_W-1:0] mem [EDGE_DEPTH];
    logic [NODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/palindromic_tree_builder.sv
// ----------------------------------------------------------------------------
// palindromic_tree_builder
// Builds a palindromic tree over a stream of letters, one result per word.
// ----------------------------------------------------------------------------
// The input channel takes a word with a letter code and a restart flag; the
// output channel returns one word per input word with the node of the longest
// palindromic suffix, its length, the created flag, its end count, its first
// end position and a status code.
// One word is in work at a time. A restart word goes straight to the done
// state; a bad letter or a full text first reads the node of the current
// longest suffix for the reported length. An appended letter walks the
// suffix links, each node reading the node memory and, where the palindrome
// fits, the text memory, then reads and checks the edge; a new node adds a
// second walk for its own suffix link. The result word enters the output
// register from the done state. The walk step is bound by the dependent
// reads of the node memory and then the text memory, each registered.
// A finished result sits in the output register, so the next input word is
// taken while the receiver stalls; a result that finds the output register
// still full waits in its last state with in_ready low.
// After reset, before the first word, the block writes zero into every edge
// entry with in_ready low. A restart word empties the tree at once: edge
// entries left from before are ignored because a child must record the same
// parent and letter.
// ----------------------------------------------------------------------------
module palindromic_tree_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptb_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ptb_pkg::out_word_t out_data
);
    import ptb_pkg::*;

    state_e            state_reg, state_next;
    logic [LEN_W-1:0]  text_len_reg, text_len_next;
    logic [NODE_W-1:0] cur_suffix_reg, cur_suffix_next;
    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic              out_valid_reg, out_valid_next;
    logic [EDGE_AW-1:0] clr_reg, clr_next;
    out_word_t         out_reg, out_next;

    logic [NODE_W-1:0] v_reg, v_next;
    logic              phase_reg, phase_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic [NODE_W-1:0] cur_link_reg, cur_link_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [NODE_W-1:0] link_reg, link_next;
    logic [NODE_W-1:0] c_reg, c_next;
    logic [NODE_W-1:0] new_node_reg, new_node_next;
    logic [LEN_W-1:0]  new_len_reg, new_len_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    out_word_t         res_reg, res_next;

    logic              text_wr_en;
    logic              text_rd_en;
    logic [POS_W-1:0]  text_rd_addr;
    logic [SYM_W-1:0]  text_rd;
    node_rd_t          node_rd;
    node_wr_t          node_wr;
    node_rec_t         node_q;
    logic              edge_wr_en;
    logic              edge_rd_en;
    logic [EDGE_AW-1:0] edge_addr;
    logic [NODE_W-1:0] edge_wr_data;
    logic [NODE_W-1:0] edge_q;

    logic              accept;
    logic              is_bad;
    logic              is_full;
    logic [LEN_W-1:0]  wn_len;
    logic [NODE_W-1:0] wn_link;
    logic              w_fits;
    logic              text_eq;
    logic              edge_cand;
    logic              chk_hit;
    logic              resolve;
    logic              hit;
    logic              out_free;
    logic [CNT_W-1:0]  cnt_inc;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_bad    = (in_data.symbol >= SYM_W'(ALPHABET));
    assign is_full   = (text_len_reg >= LEN_W'(MAX_TEXT));
    assign out_free  = !out_valid_reg || out_ready;

    assign wn_len    = (v_reg < NODE_W'(2)) ? '0 : node_q.len;
    assign wn_link   = (v_reg < NODE_W'(2)) ? '0 : node_q.link;
    assign w_fits    = (wn_len < {1'b0, pos_reg});
    assign text_eq   = (text_rd == sym_reg);
    assign edge_cand = (edge_q >= NODE_W'(2)) && (edge_q < node_count_reg);
    assign chk_hit   = (node_q.parent == v_reg) && (node_q.letter == sym_reg);
    assign resolve   = ((state_reg == S_EDGED) && !edge_cand) || (state_reg == S_CHK);
    assign hit       = (state_reg == S_CHK) && chk_hit;
    assign cnt_inc   = (node_q.cnt < COUNT_MAX) ? node_q.cnt + CNT_W'(1) : node_q.cnt;

    assign text_wr_en   = accept && !in_data.restart && !is_bad && !is_full;
    assign text_rd_addr = pos_reg - wn_len[POS_W-1:0] - POS_W'(1);
    assign edge_addr    = (state_reg == S_CLEAR) ? clr_reg :
                          EDGE_AW'(v_reg) * EDGE_AW'(ALPHABET) + EDGE_AW'(sym_reg);
    assign edge_wr_data = (state_reg == S_CLEAR) ? '0 : node_count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == EDGE_AW'(EDGE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.restart)
                    begin
                        state_next = S_DONE;
                    end
                    else if (is_bad || is_full)
                    begin
                        state_next = S_RDCUR;
                    end
                    else
                    begin
                        state_next = S_WNODE;
                    end
                end
            end
            S_RDCUR: state_next = S_CURD;
            S_CURD:  state_next = S_DONE;
            S_WNODE: state_next = S_WTEXT;
            S_WTEXT:
            begin
                if (v_reg == '0)
                begin
                    state_next = S_EDGE;
                end
                else if (w_fits)
                begin
                    state_next = S_WCMP;
                end
                else
                begin
                    state_next = S_WNODE;
                end
            end
            S_WCMP:  state_next = text_eq ? S_EDGE : S_WNODE;
            S_EDGE:  state_next = S_EDGED;
            S_EDGED, S_CHK:
            begin
                if ((state_reg == S_EDGED) && edge_cand)
                begin
                    state_next = S_CHK;
                end
                else if (!phase_reg && !hit && (v_reg != '0))
                begin
                    state_next = S_WNODE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        text_len_next   = text_len_reg;
        cur_suffix_next = cur_suffix_reg;
        node_count_next = node_count_reg;
        out_valid_next  = out_valid_reg;
        clr_next        = clr_reg;
        out_next        = out_reg;
        v_next          = v_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        cur_len_next    = cur_len_reg;
        cur_link_next   = cur_link_reg;
        wlen_next       = wlen_reg;
        link_next       = link_reg;
        c_next          = c_reg;
        new_node_next   = new_node_reg;
        new_len_next    = new_len_reg;
        sym_next        = sym_reg;
        pos_next        = pos_reg;
        res_next        = res_reg;
        text_rd_en      = 1'b0;
        node_rd         = '0;
        node_wr         = '0;
        edge_wr_en      = 1'b0;
        edge_rd_en      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                edge_wr_en = 1'b1;
                clr_next   = clr_reg + EDGE_AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (in_data.restart)
                    begin
                        text_len_next        = '0;
                        cur_suffix_next      = NODE_W'(1);
                        node_count_next      = NODE_W'(2);
                        res_next.suffix_node = 13'(1);
                        res_next.status      = ST_CLEARED;
                    end
                    else if (is_bad || is_full)
                    begin
                        res_next.status = is_bad ? ST_BAD : ST_FULL;
                    end
                    else
                    begin
                        pos_next      = text_len_reg[POS_W-1:0];
                        text_len_next = text_len_reg + LEN_W'(1);
                        sym_next      = in_data.symbol;
                        v_next        = cur_suffix_reg;
                        phase_next    = 1'b0;
                    end
                end
            end
            S_RDCUR:
            begin
                node_rd.en   = 1'b1;
                node_rd.addr = cur_suffix_reg;
            end
            S_CURD:
            begin
                res_next.suffix_node   = 13'(cur_suffix_reg);
                res_next.suffix_length = (cur_suffix_reg < NODE_W'(2)) ? '0 : 13'(node_q.len);
            end
            S_WNODE:
            begin
                node_rd.en   = 1'b1;
                node_rd.addr = v_reg;
            end
            S_WTEXT:
            begin
                wlen_next = wn_len;
                link_next = wn_link;
                if ((v_reg != '0) && w_fits)
                begin
                    text_rd_en = 1'b1;
                end
                else if (v_reg != '0)
                begin
                    v_next = wn_link;
                end
            end
            S_WCMP:
            begin
                if (!text_eq)
                begin
                    v_next = link_reg;
                end
            end
            S_EDGE:
            begin
                edge_rd_en = 1'b1;
                if (!phase_reg)
                begin
                    cur_next      = v_reg;
                    cur_len_next  = wlen_reg;
                    cur_link_next = link_reg;
                end
            end
            S_EDGED, S_CHK:
            begin
                if ((state_reg == S_EDGED) && edge_cand)
                begin
                    c_next       = edge_q;
                    node_rd.en   = 1'b1;
                    node_rd.addr = edge_q;
                end
                else if (!phase_reg && hit)
                begin
                    node_wr.en       = 1'b1;
                    node_wr.addr     = c_reg;
                    node_wr.data     = node_q;
                    node_wr.data.cnt = cnt_inc;
                    cur_suffix_next  = c_reg;
                    res_next.suffix_node    = 13'(c_reg);
                    res_next.suffix_length  = 13'(node_q.len);
                    res_next.created        = 1'b0;
                    res_next.end_count      = 13'(cnt_inc);
                    res_next.first_position = 12'(node_q.first);
                end
                else if (!phase_reg)
                begin
                    edge_wr_en      = 1'b1;
                    node_count_next = node_count_reg + NODE_W'(1);
                    new_node_next   = node_count_reg;
                    new_len_next    = (v_reg == '0) ? LEN_W'(1) : cur_len_reg + LEN_W'(2);
                    if (v_reg == '0)
                    begin
                        node_wr.en          = 1'b1;
                        node_wr.addr        = node_count_reg;
                        node_wr.data.len    = LEN_W'(1);
                        node_wr.data.link   = NODE_W'(1);
                        node_wr.data.cnt    = CNT_W'(1);
                        node_wr.data.first  = pos_reg;
                        node_wr.data.parent = v_reg;
                        node_wr.data.letter = sym_reg;
                        cur_suffix_next     = node_count_reg;
                        res_next.suffix_node    = 13'(node_count_reg);
                        res_next.suffix_length  = 13'(1);
                        res_next.created        = 1'b1;
                        res_next.end_count      = 13'(1);
                        res_next.first_position = 12'(pos_reg);
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        v_next     = cur_link_reg;
                    end
                end
                else if (resolve)
                begin
                    node_wr.en          = 1'b1;
                    node_wr.addr        = new_node_reg;
                    node_wr.data.len    = new_len_reg;
                    node_wr.data.link   = hit ? c_reg : NODE_W'(1);
                    node_wr.data.cnt    = CNT_W'(1);
                    node_wr.data.first  = pos_reg;
                    node_wr.data.parent = cur_reg;
                    node_wr.data.letter = sym_reg;
                    cur_suffix_next     = new_node_reg;
                    res_next.suffix_node    = 13'(new_node_reg);
                    res_next.suffix_length  = 13'(new_len_reg);
                    res_next.created        = 1'b1;
                    res_next.end_count      = 13'(1);
                    res_next.first_position = 12'(pos_reg);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            text_len_reg   <= '0;
            cur_suffix_reg <= NODE_W'(1);
            node_count_reg <= NODE_W'(2);
            out_valid_reg  <= 1'b0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            text_len_reg   <= text_len_next;
            cur_suffix_reg <= cur_suffix_next;
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
            clr_reg        <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        v_reg        <= v_next;
        phase_reg    <= phase_next;
        cur_reg      <= cur_next;
        cur_len_reg  <= cur_len_next;
        cur_link_reg <= cur_link_next;
        wlen_reg     <= wlen_next;
        link_reg     <= link_next;
        c_reg        <= c_next;
        new_node_reg <= new_node_next;
        new_len_reg  <= new_len_next;
        sym_reg      <= sym_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
    end

    ptb_text_store u_text (
        .clk     (clk),
        .wr_en   (text_wr_en),
        .wr_addr (text_len_reg[POS_W-1:0]),
        .wr_data (in_data.symbol),
        .rd_en   (text_rd_en),
        .rd_addr (text_rd_addr),
        .rd_data (text_rd)
    );

    ptb_node_store u_node (
        .clk     (clk),
        .rd      (node_rd),
        .wr      (node_wr),
        .rd_data (node_q)
    );

    ptb_edge_store u_edge (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .rd_en   (edge_rd_en),
        .addr    (edge_addr),
        .wr_data (edge_wr_data),
        .rd_data (edge_q)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/core/ptb_checker.sv
// ----------------------------------------------------------------------------
// ptb_checker
// Port-level checks of the palindromic tree builder, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ptb_pkg::in_word_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input ptb_pkg::out_word_t out_data
);
    import ptb_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output word changed while stalled.");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_CLEARED) |->
        (out_data.suffix_node == 13'd1) && (out_data.suffix_length == '0) &&
        !out_data.created && (out_data.end_count == '0))
        else $error("Cleared word carries tree data.");

    a_created: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.created |->
        (out_data.status == ST_APPENDED) && (out_data.end_count == 13'd1) &&
        (out_data.suffix_node >= 13'd2))
        else $error("New node word is inconsistent.");

    a_not_created: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_APPENDED) |-> !out_data.created)
        else $error("Ignored word reports a new node.");

endmodule

bind palindromic_tree_builder ptb_checker u_ptb_checker (.*);

### bench/palindromic_tree_builder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_checker
// Watches both channels of the palindromic tree builder, predicts every
// result word from the accepted input words with its own tree model, and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ptb_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ptb_pkg::out_word_t out_data,
    output int                 failures,
    output int                 pending
);
    import ptb_pkg::*;

    byte unsigned text_sym [MAX_TEXT];
    int text_len;
    int longest_sfx;
    int nodes_used;
    int pal_len [NODES];
    int pal_link [NODES];
    int pal_count [NODES];
    int pal_first [NODES];
    int child_of [int];
    out_word_t expected_words [$];

    function automatic void clear_tree();
        child_of.delete();
        pal_len[0] = -1;
        pal_len[1] = 0;
        pal_link[0] = 0;
        pal_link[1] = 0;
        text_len = 0;
        longest_sfx = 1;
        nodes_used = 2;
    endfunction

    function automatic int child(int node, int sym);
        int key;
        key = node * ALPHABET + sym;
        return child_of.exists(key) ? child_of[key] : 0;
    endfunction

    function automatic int wrap_node(int v, int pos, int sym);
        int idx;
        for (int g = 0; g < NODES + 2; g++)
        begin
            if (v >= NODES)
                return 0;
            idx = pos - pal_len[v] - 1;
            if (idx == pos)
                return v;
            if (idx >= 0 && idx < pos && text_sym[idx] == sym)
                return v;
            v = pal_link[v];
        end
        return 0;
    endfunction

    function automatic out_word_t tree_step(in_word_t w);
        out_word_t r;
        int sym, pos, cur, nxt, v, p, lk;
        r = '0;
        sym = w.symbol;
        if (w.restart)
        begin
            clear_tree();
            r.suffix_node = 13'd1;
            r.status = ST_CLEARED;
            return r;
        end
        if (sym >= ALPHABET || text_len >= MAX_TEXT)
        begin
            r.suffix_node = 13'(longest_sfx);
            r.suffix_length = 13'(pal_len[longest_sfx] < 0 ? 0 : pal_len[longest_sfx]);
            r.status = sym >= ALPHABET ? ST_BAD : ST_FULL;
            return r;
        end
        pos = text_len;
        text_sym[pos] = 8'(sym);
        text_len = pos + 1;
        cur = wrap_node(longest_sfx, pos, sym);
        nxt = child(cur, sym);
        if (nxt != 0 && nxt < NODES)
        begin
            longest_sfx = nxt;
            if (pal_count[nxt] < COUNT_MAX)
                pal_count[nxt]++;
            r.suffix_node = 13'(nxt);
            r.suffix_length = 13'(pal_len[nxt]);
            r.end_count = 13'(pal_count[nxt]);
            r.first_position = 12'(pal_first[nxt]);
            r.status = ST_APPENDED;
            return r;
        end
        v = nodes_used;
        if (v >= NODES)
            v = NODES - 1;
        else
            nodes_used = v + 1;
        pal_len[v] = pal_len[cur] + 2;
        pal_first[v] = pos;
        pal_count[v] = 1;
        pal_link[v] = 1;
        child_of[cur * ALPHABET + sym] = v;
        if (pal_len[v] != 1)
        begin
            p = wrap_node(pal_link[cur], pos, sym);
            lk = child(p, sym);
            pal_link[v] = (lk != 0 && lk < NODES) ? lk : 1;
        end
        longest_sfx = v;
        r.suffix_node = 13'(v);
        r.suffix_length = 13'(pal_len[v]);
        r.created = 1'b1;
        r.end_count = 13'd1;
        r.first_position = 12'(pos);
        r.status = ST_APPENDED;
        return r;
    endfunction

    task automatic field_check(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                act_v);
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            failures = 0;
            expected_words.delete();
            clear_tree();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_words = {expected_words, tree_step(in_data)};
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    failures++;
                    $display("%0t: result word with none expected, actual %h", $time,
                        out_data);
                end
                else
                begin
                    e = expected_words.pop_front();
                    field_check("suffix_node", e.suffix_node, out_data.suffix_node);
                    field_check("suffix_length", e.suffix_length, out_data.suffix_length);
                    field_check("created", e.created, out_data.created);
                    field_check("end_count", e.end_count, out_data.end_count);
                    field_check("first_position", e.first_position,
                        out_data.first_position);
                    field_check("status", e.status, out_data.status);
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

### bench/palindromic_tree_builder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_test
// Drives letter words into the palindromic tree builder with random gaps and
// output stalls, including a long output hold-off and a drain pause, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_test;
    import ptb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    int        failures;
    int        pending;
    logic      took_word;
    bit        calm;
    bit        hold_req;
    int        cycles = 0;

    palindromic_tree_builder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    palindromic_tree_builder_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        took_word <= in_valid && in_ready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    task automatic send_word(int sym, bit rst);
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{symbol: sym[4:0], restart: rst};
        do
            @(negedge clk);
        while (!took_word);
    endtask

    function automatic int pick_symbol(int span);
        if ($urandom_range(99) < 4)
            return $urandom_range(31, ALPHABET);
        return $urandom_range(span - 1);
    endfunction

    initial
    begin
        int span;
        string seed_text;
        seed_text = "abaabaab";
        calm = 1'b0;
        hold_req = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(0, 1'b0);
        send_word(25, 1'b0);
        send_word(26, 1'b0);
        send_word(31, 1'b0);
        send_word(25, 1'b0);
        send_word(0, 1'b0);
        send_word(0, 1'b1);
        for (int i = 0; i < seed_text.len(); i++)
            send_word(int'(seed_text[i] - "a"), 1'b0);
        send_word(0, 1'b1);
        send_word(27, 1'b0);
        send_word(21, 1'b1);
        send_word(10, 1'b0);
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        span = 2;
        for (int n = 0; n < 1300; n++)
        begin
            calm = (n >= 300 && n < 450);
            if (n == 600)
                hold_req = 1'b1;
            if (n == 900)
            begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            if ($urandom_range(99) < 2)
            begin
                send_word($urandom_range(31), 1'b1);
                case ($urandom_range(3))
                    0: span = 1;
                    1: span = 2;
                    2: span = 3;
                    default: span = ALPHABET;
                endcase
            end
            else
                send_word(pick_symbol(span), 1'b0);
        end

        send_word(30, 1'b0);
        send_word(0, 1'b0);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(negedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
